// ===== rtl/vertex_project_to_screen_defines.svh =====
// Assertion macros used by the RTL file vertex_project_to_screen.sv
`ifndef VERTEX_PROJECT_TO_SCREEN_DEFINES_SVH
`define VERTEX_PROJECT_TO_SCREEN_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define VPTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, for an overlapping implication (ante |-> cons) written by the caller
`define VPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `VPTS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)
`else
`define VPTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/vpts_pkg.sv =====
package vpts_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROW0_A  = 3'd0,
        CFG_ROW0_B  = 3'd1,
        CFG_ROW1_A  = 3'd2,
        CFG_ROW1_B  = 3'd3,
        CFG_ROW2_A  = 3'd4,
        CFG_ROW2_B  = 3'd5,
        CFG_PERSP   = 3'd6
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned NUM_ROWS   = 6;

    // Q16.16 word and perspective scale (2.0 = 1 << 17)
    localparam int unsigned Q_W        = 32;
    localparam int unsigned FACTOR_SH  = 17;
    // dividend |t| << 17 needs 49 bits, one quotient bit per divider stage
    localparam int unsigned DIV_STEPS  = Q_W + FACTOR_SH;
    localparam logic signed [Q_W-1:0] PERSP_Z = -32'sd131072;
    localparam logic signed [Q_W-1:0] ONE_Q   = 32'sd65536;

    localparam logic [CFG_DATA_W-1:0] ROW0_A_RST = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] ROW1_A_RST = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW2_B_RST = 64'h0000_0000_0001_0000;

    // saturate a wide signed value to Q16.16
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return -32'sd2147483648;
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

    // magnitude of a signed word; -2^31 gives 2^31
    function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
        logic signed [Q_W:0] e;
        e = Q_W'(0) + (Q_W+1)'(v);
        if (v[Q_W-1]) begin
            e = -e;
        end
        return e[Q_W-1:0];
    endfunction

endpackage

// ===== rtl/vertex_project_to_screen.sv =====
// Throughput: one item per cycle while the output is not held by
// i_m_axis_tready; the 49-stage restoring divider for the perspective
// scale takes one quotient bit per stage and sets the depth.
// A one-item skid on the input keeps o_s_axis_tready registered.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// identity matrix with orthographic mode.
`include "vertex_project_to_screen_defines.svh"

module vertex_project_to_screen
    import vpts_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // vertex in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [95:0]           i_s_axis_tdata,  // vert_x, vert_y, vert_z
    // result out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [95:0]           o_m_axis_tdata,  // pixel x, pixel y, proj_z
    output logic [1:0]            o_m_axis_tuser   // culled, divide_fault
);

    localparam int HB = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW = Q_W + HB + 1;
    localparam logic signed [HB:0] HQ = (HB+1)'(SCREEN_HEIGHT);
    localparam logic signed [65:0] WOFF = 66'(SCREEN_WIDTH) * 66'sd32768;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_row [NUM_ROWS];
    logic                  r_persp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_A_RST;
            r_row[1] <= '0;
            r_row[2] <= ROW1_A_RST;
            r_row[3] <= '0;
            r_row[4] <= '0;
            r_row[5] <= ROW2_B_RST;
            r_persp  <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ROW0_A, CFG_ROW0_B, CFG_ROW1_A,
                CFG_ROW1_B, CFG_ROW2_A, CFG_ROW2_B: begin
                    r_row[i_cfg_idx] <= i_cfg_data;
                end
                CFG_PERSP: begin
                    r_persp <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // matrix entries
    logic signed [Q_W-1:0] m [3][4];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            m[r][0] = r_row[2*r][31:0];
            m[r][1] = r_row[2*r][63:32];
            m[r][2] = r_row[2*r+1][31:0];
            m[r][3] = r_row[2*r+1][63:32];
        end
    end

    // pipeline advances unless the output holds an untaken item
    logic en;
    logic r_ov;
    assign en = !r_ov || i_m_axis_tready;

    // input skid
    logic        r_skv;
    logic [95:0] r_skd;
    assign o_s_axis_tready = !r_skv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skv <= 1'b0;
        end else if (en) begin
            r_skv <= 1'b0;
        end else if (i_s_axis_tvalid && !r_skv) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_s_axis_tvalid && !r_skv) begin
            r_skd <= i_s_axis_tdata;
        end
    end

    // stage 1: vertex register
    logic                  r1_v;
    logic signed [Q_W-1:0] r1_c [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r_skv || i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_c[i] <= r_skv ? r_skd[32*i +: 32] : i_s_axis_tdata[32*i +: 32];
            end
        end
    end

    // stage 2: nine products
    logic              r2_v;
    logic signed [63:0] r2_p [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_p[r][c] <= 64'(m[r][c]) * 64'(r1_c[c]);
                end
            end
        end
    end

    // stage 3: partial sums, translation aligned to the product scale
    logic               r3_v;
    logic signed [64:0] r3_a [3];
    logic signed [64:0] r3_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r3_a[r] <= 65'(r2_p[r][0]) + 65'(r2_p[r][1]);
                r3_b[r] <= 65'(r2_p[r][2]) + {{17{m[r][3][31]}}, m[r][3], 16'h0};
            end
        end
    end

    // stage 4: floor to Q16.16 and saturate
    logic                  r4_v;
    logic signed [Q_W-1:0] r4_t [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r4_t[r] <= sat32((66'(r3_a[r]) + 66'(r3_b[r])) >>> 16);
            end
        end
    end

    // divider: stage 0 prepares magnitudes, stages 1..DIV_STEPS one bit each
    logic                  dv_v   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]  dv_a   [DIV_STEPS+1][2];
    logic [Q_W-1:0]        dv_r   [DIV_STEPS+1][2];
    logic [Q_W-1:0]        dv_den [DIV_STEPS+1];
    logic                  dv_neg [DIV_STEPS+1][2];
    logic                  dv_flt [DIV_STEPS+1];
    logic signed [Q_W-1:0] dv_t   [DIV_STEPS+1][3];

    logic den_neg;
    assign den_neg = !r4_t[2][Q_W-1] && (r4_t[2] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_den[0] <= mag32(r4_t[2]);
            dv_flt[0] <= r_persp && (r4_t[2] == '0);
            for (int j = 0; j < 2; j++) begin
                dv_a[0][j]   <= {mag32(r4_t[j]), FACTOR_SH'(0)};
                dv_r[0][j]   <= '0;
                dv_neg[0][j] <= r4_t[j][Q_W-1] ^ den_neg;
            end
            for (int r = 0; r < 3; r++) begin
                dv_t[0][r] <= r4_t[r];
            end
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [Q_W:0] trial [2];
        logic         ge    [2];

        always_comb begin
            for (int j = 0; j < 2; j++) begin
                trial[j] = {dv_r[k-1][j], dv_a[k-1][j][DIV_STEPS-1]};
                ge[j]    = trial[j] >= {1'b0, dv_den[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[k] <= 1'b0;
            end else if (en) begin
                dv_v[k] <= dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                dv_den[k] <= dv_den[k-1];
                dv_flt[k] <= dv_flt[k-1];
                for (int j = 0; j < 2; j++) begin
                    dv_a[k][j]   <= {dv_a[k-1][j][DIV_STEPS-2:0], ge[j]};
                    dv_r[k][j]   <= ge[j] ? Q_W'(trial[j] - {1'b0, dv_den[k-1]})
                                          : trial[j][Q_W-1:0];
                    dv_neg[k][j] <= dv_neg[k-1][j];
                end
                for (int r = 0; r < 3; r++) begin
                    dv_t[k][r] <= dv_t[k-1][r];
                end
            end
        end
    end

    // stage 6: signed, saturated quotients or orthographic pass-through
    logic                  r6_v;
    logic                  r6_flt;
    logic signed [Q_W-1:0] r6_p [3];
    logic signed [Q_W-1:0] qs   [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            if (!dv_neg[DIV_STEPS][j]) begin
                qs[j] = (dv_a[DIV_STEPS][j] > DIV_STEPS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                        : dv_a[DIV_STEPS][j][Q_W-1:0];
            end else begin
                qs[j] = (dv_a[DIV_STEPS][j] > DIV_STEPS'(32'h8000_0000)) ? 32'sh8000_0000
                        : -dv_a[DIV_STEPS][j][Q_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_flt  <= dv_flt[DIV_STEPS];
            r6_p[0] <= r_persp ? qs[0] : dv_t[DIV_STEPS][0];
            r6_p[1] <= r_persp ? qs[1] : dv_t[DIV_STEPS][1];
            r6_p[2] <= r_persp ? PERSP_Z : dv_t[DIV_STEPS][2];
        end
    end

    // stage 7: scale by screen height (y after adding 1.0)
    logic                  r7_v;
    logic                  r7_flt;
    logic signed [PW-1:0]  r7_mx;
    logic signed [PW:0]    r7_my;
    logic signed [Q_W-1:0] r7_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_flt <= r6_flt;
            r7_pz  <= r6_p[2];
            r7_mx  <= PW'(r6_p[0]) * PW'(HQ);
            r7_my  <= ((PW+1)'(r6_p[1]) + (PW+1)'(ONE_Q)) * (PW+1)'(HQ);
        end
    end

    // output register: halve, offset, saturate, fault override
    logic signed [Q_W-1:0] r_sx, r_sy, r_pz;
    logic                  r_cul, r_flt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r7_flt) begin
                r_sx  <= '0;
                r_sy  <= '0;
                r_pz  <= '0;
                r_cul <= 1'b1;
                r_flt <= 1'b1;
            end else begin
                r_sx  <= sat32((66'(r7_mx) >>> 1) + WOFF);
                r_sy  <= sat32(66'(r7_my) >>> 1);
                r_pz  <= r7_pz;
                r_cul <= !r7_pz[Q_W-1];
                r_flt <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_pz, r_sy, r_sx};
    assign o_m_axis_tuser  = {r_flt, r_cul};

    // checks
    `VPTS_ASSERT_IMP(a_fault_out, i_clk, i_rst_n, r_ov && r_flt,
        r_cul && (r_sx == '0) && (r_sy == '0) && (r_pz == '0), "fault item not zeroed")
    `VPTS_ASSERT_IMP(a_fault_persp, i_clk, i_rst_n, r_ov && r_flt, r_persp,
        "divide fault in orthographic mode")
    `VPTS_ASSERT_IMP(a_persp_depth, i_clk, i_rst_n, r_ov && r_persp && !r_flt,
        r_pz == PERSP_Z, "perspective depth not -2.0")
    `VPTS_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skv) |-> !$past(en),
        "skid filled while pipeline moving")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import vpts_pkg::*;

    localparam int SCR_W     = 1024;
    localparam int SCR_H     = 768;
    localparam int LATENCY   = 56;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // expected / observed screen item
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] pz;
        logic               culled;
        logic               fault;
    } t_screen;

    // directed row: vertex, whether perspective is on, optional typed result
    typedef struct {
        logic signed [31:0] x, y, z;
        bit                 persp;
        bit                 typed;
        t_screen            res;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [95:0]           i_s_axis_tdata;   // vert_x, vert_y, vert_z
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [95:0]           o_m_axis_tdata;   // pixel x, pixel y, proj_z
    logic [1:0]            o_m_axis_tuser;   // culled, divide_fault

    vertex_project_to_screen #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (.*);

    // predictor copy of the configuration
    logic [63:0] mvp_rows [NUM_ROWS];
    bit          persp_en;

    t_screen     screen_q [$];
    int          errors;
    int          n_sent;
    int          n_seen;
    int          n_faults;
    int          n_culled;
    int          cycles;
    bit          quiet;
    bit          hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run guard
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat_q(input logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -72'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // one row of the matrix times (x, y, z, 1), floored to Q16.16
    function automatic logic signed [31:0] row_dot(input int r, input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
        logic signed [31:0] m0, m1, m2, m3;
        logic signed [71:0] acc;
        m0 = mvp_rows[2*r][31:0];
        m1 = mvp_rows[2*r][63:32];
        m2 = mvp_rows[2*r+1][31:0];
        m3 = mvp_rows[2*r+1][63:32];
        acc = m0 * x;
        acc = acc + m1 * y;
        acc = acc + m2 * z;
        acc = acc + (72'(m3) <<< 16);
        return sat_q(acc >>> 16);
    endfunction

    function automatic logic signed [31:0] persp_scale(input logic signed [31:0] t,
                                                       input logic signed [31:0] tz);
        longint num, den;
        num = longint'(t) * 131072;
        den = -longint'(tz);
        return sat_q(72'(num / den));
    endfunction

    function automatic t_screen project_vertex(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] z);
        logic signed [31:0] tx, ty, tz, px, py, pz;
        t_screen r;
        tx = row_dot(0, x, y, z);
        ty = row_dot(1, x, y, z);
        tz = row_dot(2, x, y, z);
        if (persp_en && tz == 0) begin
            r = '{sx: 0, sy: 0, pz: 0, culled: 1'b1, fault: 1'b1};
            return r;
        end
        if (persp_en) begin
            px = persp_scale(tx, tz);
            py = persp_scale(ty, tz);
            pz = persp_scale(tz, tz);
        end else begin
            px = tx;
            py = ty;
            pz = tz;
        end
        r.sx = sat_q(72'((longint'(px) * SCR_H) >>> 1) + 72'(SCR_W * 32768));
        r.sy = sat_q(72'(((longint'(py) + 65536) * SCR_H) >>> 1));
        r.pz = pz;
        r.culled = (pz >= 0);
        r.fault = 1'b0;
        return r;
    endfunction

    // register write; predictor copy follows
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_wen  <= 1'b0;
        if (idx < NUM_ROWS) mvp_rows[idx] = data;
        else if (idx == CFG_PERSP) persp_en = data[0];
    endtask

    task automatic drain();
        wait (screen_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // offer one vertex; expectation queued on acceptance
    task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z, input bit typed,
                               input t_screen res);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        screen_q.insert(screen_q.size(), typed ? res : project_vertex(x, y, z));
        n_sent++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'h0;
            default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off, none at the end
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                i_m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_screen got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tdata[95:64],
                   o_m_axis_tuser[0], o_m_axis_tuser[1]};
            n_seen++;
            if (got.fault) n_faults++;
            if (got.culled) n_culled++;
            if (screen_q.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                errors++;
            end else begin
                want = screen_q.pop_front();
                if (got.sx !== want.sx) begin
                    $display("%0t: pixel x exp %h got %h", $time, want.sx, got.sx);
                    errors++;
                end
                if (got.sy !== want.sy) begin
                    $display("%0t: pixel y exp %h got %h", $time, want.sy, got.sy);
                    errors++;
                end
                if (got.pz !== want.pz) begin
                    $display("%0t: proj_z exp %h got %h", $time, want.pz, got.pz);
                    errors++;
                end
                if (got.culled !== want.culled) begin
                    $display("%0t: culled exp %b got %b", $time, want.culled, got.culled);
                    errors++;
                end
                if (got.fault !== want.fault) begin
                    $display("%0t: divide_fault exp %b got %b", $time, want.fault, got.fault);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row dir_rows [$];
        t_screen none;
        int phase;
        int i;
        bit cur_persp;

        none = '0;
        errors = 0; n_sent = 0; n_seen = 0; n_faults = 0; n_culled = 0;
        quiet = 1'b0; hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0;
        mvp_rows[0] = ROW0_A_RST; mvp_rows[1] = '0;
        mvp_rows[2] = ROW1_A_RST; mvp_rows[3] = '0;
        mvp_rows[4] = '0;         mvp_rows[5] = ROW2_B_RST;
        persp_en = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, orthographic: centre, depth sign, saturation at the field extremes
        dir_rows.insert(dir_rows.size(),
                        '{0, 0, 0, 0, 1, '{32'h0200_0000, 32'h0180_0000, 0, 1, 0}});
        dir_rows.insert(dir_rows.size(), '{0, 0, -65536, 0, 1,
                             '{32'h0200_0000, 32'h0180_0000, -65536, 0, 0}});
        dir_rows.insert(dir_rows.size(), '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1,
                             '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0}});
        dir_rows.insert(dir_rows.size(), '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 1,
                             '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0}});
        dir_rows.insert(dir_rows.size(), '{65536, -65536, -1, 0, 0, none});
        dir_rows.insert(dir_rows.size(), '{-1, -1, 1, 0, 0, none});
        dir_rows.insert(dir_rows.size(),
                        '{32'sh0001_8000, -32'sh0000_4000, -32'sh0003_0000, 0, 0, none});
        // perspective: divide fault on zero depth, near/far depths, signed extremes
        dir_rows.insert(dir_rows.size(), '{0, 0, 0, 1, 1, '{0, 0, 0, 1, 1}});
        dir_rows.insert(dir_rows.size(),
                        '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 1, '{0, 0, 0, 1, 1}});
        dir_rows.insert(dir_rows.size(), '{65536, 65536, -65536, 1, 0, none});
        dir_rows.insert(dir_rows.size(), '{-65536, 32768, -1, 1, 0, none});
        dir_rows.insert(dir_rows.size(),
                        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, none});
        dir_rows.insert(dir_rows.size(),
                        '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, none});
        dir_rows.insert(dir_rows.size(), '{12345, -54321, 1, 1, 0, none});
        dir_rows.insert(dir_rows.size(), '{0, 0, 32'sh0010_0000, 1, 0, none});

        cur_persp = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].persp != cur_persp) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                drain();
                cfg_write(CFG_PERSP, {$urandom, 31'(0), dir_rows[k].persp});
                cur_persp = dir_rows[k].persp;
            end
            send_vertex(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].typed,
                        dir_rows[k].res);
        end

        // random phases, each with its own matrix and mode
        for (phase = 0; phase < 8; phase++) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            drain();
            quiet = (phase == 7);
            for (i = 0; i < NUM_ROWS; i++) begin
                case (phase)
                    1:       cfg_write(CFG_IDX_W'(i), 64'h7FFF_FFFF_7FFF_FFFF);
                    2:       cfg_write(CFG_IDX_W'(i), 64'h8000_0000_8000_0000);
                    3:       cfg_write(CFG_IDX_W'(i), 64'h0);
                    default: cfg_write(CFG_IDX_W'(i), {rand_entry(), rand_entry()});
                endcase
            end
            // out-of-range index must be ignored by the block
            cfg_write(CFG_UNUSED, {$urandom, $urandom});
            cfg_write(CFG_PERSP, {$urandom, $urandom_range(0, 1) == 0 ? 32'h0 : 32'hFFFF_FFFF}
                                 ^ 64'(phase[0]));
            if (phase == 4) hold_req = 1'b1;
            for (i = 0; i < 50; i++)
                send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        drain();
        if (screen_q.size() != 0) begin
            $display("%0t: results outstanding exp 0 got %0d", $time, screen_q.size());
            errors++;
        end
        $display("Sent %0d vertices: identity matrix plus eight loaded ones, ortho and perspective.",
                 n_sent);
        $display("Checked %0d results: %0d culled, %0d divide faults.",
                 n_seen, n_culled, n_faults);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
